FILE: rtl/sfs_pkg.sv
// sfs_pkg: shared types and constants of the shot feed sequencer.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package sfs_pkg;

	localparam int PHASE_W = 3;
	localparam int COUNT_W = 8;
	localparam int DRIVE_W = 16;
	localparam int SPEED_W = 16;
	localparam int TARGET_W = 14;
	localparam int MARGIN_W = 12;
	localparam int DIFF_W = SPEED_W + 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [PHASE_W-1:0] PH_RAMP      = 3'd0;
	localparam logic [PHASE_W-1:0] PH_PUNCH     = 3'd1;
	localparam logic [PHASE_W-1:0] PH_RETRACT   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_ADVANCE   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_ADVANCING = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_EXTEND_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_MARGIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_MARGIN = 2'd2;

	localparam logic [COUNT_W-1:0]  RST_EXTEND_TICKS = 8'd10;
	localparam logic [MARGIN_W-1:0] RST_UPPER_MARGIN = 12'd300;
	localparam logic [MARGIN_W-1:0] RST_LOWER_MARGIN = 12'd100;
	localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

	typedef struct packed {
		logic                       shoot_enable;
		logic signed [SPEED_W-1:0]  flywheel_speed;
		logic [TARGET_W-1:0]        target_speed;
		logic signed [DRIVE_W-1:0]  feed_speed;
		logic                       punch_home_switch;
		logic                       index_switch;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  extend_ticks;
		logic [MARGIN_W-1:0] upper_margin;
		logic [MARGIN_W-1:0] lower_margin;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0]        phase;
		logic [PHASE_W-1:0]        prev_phase;
		logic [COUNT_W-1:0]        extend_cnt;
		logic [COUNT_W-1:0]        punches;
		logic signed [DRIVE_W-1:0] drive;
		logic                      extend;
	} seq_state_t;

endpackage
`default_nettype wire

FILE: rtl/sfs_in_stage.sv
// sfs_in_stage: input register of the sequencer, one beat deep.
// Depends on sfs_pkg for the item type.
`default_nettype none
module sfs_in_stage (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  sfs_pkg::item_t   item_in,
	input  wire              take,
	output logic             valid_s1,
	output sfs_pkg::item_t   item_s1
);
	import sfs_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sfs_step.sv
// sfs_step: next-state logic of one tick (speed window, phase change, drive).
// Depends on sfs_pkg for item, config and state types.
`default_nettype none
module sfs_step (
	input  sfs_pkg::item_t      item,
	input  sfs_pkg::cfg_t       cfg,
	input  sfs_pkg::seq_state_t cur,
	output sfs_pkg::seq_state_t nxt
);
	import sfs_pkg::*;

	logic signed [DIFF_W-1:0] speed_x;
	logic signed [DIFF_W-1:0] mag;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] upper_x;
	logic signed [DIFF_W-1:0] lower_neg;
	logic                     in_window;
	logic [PHASE_W-1:0]       ph;

	assign speed_x   = DIFF_W'(item.flywheel_speed);
	assign mag       = speed_x[DIFF_W-1] ? -speed_x : speed_x;
	assign diff      = mag - $signed({{(DIFF_W-TARGET_W){1'b0}}, item.target_speed});
	assign upper_x   = $signed({{(DIFF_W-MARGIN_W){1'b0}}, cfg.upper_margin});
	assign lower_neg = -$signed({{(DIFF_W-MARGIN_W){1'b0}}, cfg.lower_margin});
	assign in_window = (diff < upper_x) && (diff > lower_neg);

	always_comb begin
		nxt = cur;
		ph  = cur.phase;
		if (!item.shoot_enable) begin
			if (cur.extend) begin
				nxt.extend = 1'b0;
			end else if (item.index_switch) begin
				nxt.drive = '0;
			end
			nxt.phase   = PH_RAMP;
			nxt.punches = '0;
		end else begin
			case (cur.phase)
				PH_RAMP: begin
					if (in_window) ph = PH_PUNCH;
				end
				PH_PUNCH: begin
					if (cur.extend_cnt > cfg.extend_ticks) begin
						ph = PH_RETRACT;
						nxt.extend_cnt = '0;
					end
				end
				PH_RETRACT: begin
					if (item.punch_home_switch) begin
						ph = PH_ADVANCE;
						nxt.extend_cnt = '0;
					end
				end
				PH_ADVANCE: begin
					if (!item.index_switch) ph = PH_ADVANCING;
				end
				PH_ADVANCING: begin
					if (item.index_switch) ph = PH_RAMP;
				end
				default: ;
			endcase

			case (ph)
				PH_RAMP: nxt.drive = '0;
				PH_PUNCH: begin
					nxt.extend = 1'b1;
					if (nxt.extend_cnt != COUNT_MAX) nxt.extend_cnt = nxt.extend_cnt + 1'b1;
				end
				PH_RETRACT: begin
					if (cur.prev_phase != PH_RETRACT && cur.punches != COUNT_MAX)
						nxt.punches = cur.punches + 1'b1;
					nxt.extend = 1'b0;
				end
				PH_ADVANCE, PH_ADVANCING: nxt.drive = item.feed_speed;
				default: ;
			endcase

			nxt.phase      = ph;
			nxt.prev_phase = ph;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/shot_feed_sequencer_core.sv
// shot_feed_sequencer_core: top level of the shot feed sequencer.
// Depends on sfs_pkg, sfs_in_stage and sfs_step.
//
// Usage:
//  - Input channel in_valid/in_ready carries one control tick per beat.
//  - Output channel out_valid/out_ready carries one result beat per tick:
//    phase, index_drive, punch_extend and punch_count after that tick.
//  - Configuration: cfg_we writes cfg_data into register cfg_index
//    (0 extend_ticks, 1 upper_margin, 2 lower_margin); other indexes are
//    ignored. Write only while no tick is in flight.
//  - Path: an accepted beat is held in the input register, then in the
//    sequencer state register, which drives the result beat.
//  - Throughput: one beat per cycle while out_ready is high; the phase
//    logic is one subtract, two negations, a few compares, 8-bit counters.
//  - Reset: state returns to ramp phase with counters, drive and punch
//    cleared; registers take their default values; both channels empty.
//  - Stall: a held result keeps its value; the input register still takes
//    one more beat, after which in_ready drops until out_ready returns.
`default_nettype none
module shot_feed_sequencer_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [sfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [sfs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                shoot_enable,
	input  wire  signed [sfs_pkg::SPEED_W-1:0] flywheel_speed,
	input  wire  [sfs_pkg::TARGET_W-1:0]       target_speed,
	input  wire  signed [sfs_pkg::DRIVE_W-1:0] feed_speed,
	input  wire                                punch_home_switch,
	input  wire                                index_switch,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [sfs_pkg::PHASE_W-1:0]        phase,
	output logic signed [sfs_pkg::DRIVE_W-1:0] index_drive,
	output logic                               punch_extend,
	output logic [sfs_pkg::COUNT_W-1:0]        punch_count
);
	import sfs_pkg::*;

	item_t      item_in;
	item_t      item_s1;
	logic       valid_s1;
	logic       take;
	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	logic       out_valid_q;

	assign item_in = '{
		shoot_enable:      shoot_enable,
		flywheel_speed:    flywheel_speed,
		target_speed:      target_speed,
		feed_speed:        feed_speed,
		punch_home_switch: punch_home_switch,
		index_switch:      index_switch
	};

	assign take = valid_s1 && (!out_valid_q || out_ready);

	sfs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sfs_step u_step (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.extend_ticks <= RST_EXTEND_TICKS;
			cfg_q.upper_margin <= RST_UPPER_MARGIN;
			cfg_q.lower_margin <= RST_LOWER_MARGIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXTEND_TICKS: cfg_q.extend_ticks <= cfg_data[COUNT_W-1:0];
				REG_UPPER_MARGIN: cfg_q.upper_margin <= cfg_data[MARGIN_W-1:0];
				REG_LOWER_MARGIN: cfg_q.lower_margin <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) state_q <= state_nxt;
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat mirrors the state after its tick
	assign out_valid    = out_valid_q;
	assign phase        = state_q.phase;
	assign index_drive  = state_q.drive;
	assign punch_extend = state_q.extend;
	assign punch_count  = state_q.punches;

endmodule
`default_nettype wire

FILE: rtl/sfs_checker.sv
// sfs_checker: port-level checks of the shot feed sequencer, bound to the top.
// Depends on sfs_pkg for phase codes and widths.
`default_nettype none
module sfs_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire  [sfs_pkg::PHASE_W-1:0]        phase,
	input wire  signed [sfs_pkg::DRIVE_W-1:0] index_drive,
	input wire                                punch_extend,
	input wire  [sfs_pkg::COUNT_W-1:0]        punch_count
);
	import sfs_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(index_drive)
			&& $stable(punch_extend) && $stable(punch_count))
		else $error("result beat changed while stalled");

	a_punch_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_PUNCH |-> punch_extend)
		else $error("punch phase without punch extended");

	a_retract: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_RETRACT |-> !punch_extend && punch_count != '0)
		else $error("retract beat with punch out or no punch counted");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (phase == PH_ADVANCE || phase == PH_ADVANCING) |-> !punch_extend)
		else $error("indexer spinning with punch extended");

endmodule

bind shot_feed_sequencer_core sfs_checker u_sfs_checker (.*);
`default_nettype wire

FILE: bench/shot_feed_sequencer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for shot_feed_sequencer_core: directed table, then random shot sequences
// under several register settings, each beat checked against a typed value or an in-bench copy.
// Depends on sfs_pkg and the RTL of shot_feed_sequencer_core.
module shot_feed_sequencer_core_tb;
	import sfs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [PHASE_W-1:0]        phase;
		logic signed [DRIVE_W-1:0] drive;
		logic                      extend;
		logic [COUNT_W-1:0]        count;
	} shot_res_t;

	typedef struct packed {
		item_t     tick;
		int        reps;
		bit        typed;
		shot_res_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic shoot_enable = 1'b0;
	logic signed [SPEED_W-1:0] flywheel_speed = '0;
	logic [TARGET_W-1:0] target_speed = '0;
	logic signed [DRIVE_W-1:0] feed_speed = '0;
	logic punch_home_switch = 1'b0;
	logic index_switch = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PHASE_W-1:0] phase;
	logic signed [DRIVE_W-1:0] index_drive;
	logic punch_extend;
	logic [COUNT_W-1:0] punch_count;

	seq_state_t seq;
	cfg_t regs;
	shot_res_t due_results[$];
	shot_res_t head;
	dir_row_t opening_ticks[$];
	bit idle_on = 1'b0;
	bit idle_ok = 1'b1;
	int stall_left = 0;
	int mismatches = 0;
	int sent = 0;
	int checked = 0;
	int peak_punches = 0;
	int peak_extend = 0;
	int unsigned cycles = 0;

	shot_feed_sequencer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.shoot_enable(shoot_enable),
		.flywheel_speed(flywheel_speed),
		.target_speed(target_speed),
		.feed_speed(feed_speed),
		.punch_home_switch(punch_home_switch),
		.index_switch(index_switch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.phase(phase),
		.index_drive(index_drive),
		.punch_extend(punch_extend),
		.punch_count(punch_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one control tick of the sequencer
	function automatic shot_res_t sequence_tick(input item_t t);
		shot_res_t r;
		int mag;
		int diff;
		bit win;
		if (!t.shoot_enable) begin
			if (seq.extend)
				seq.extend = 1'b0;
			else if (t.index_switch)
				seq.drive = '0;
			seq.phase = PH_RAMP;
			seq.punches = '0;
		end else begin
			mag = int'($signed(t.flywheel_speed));
			if (mag < 0)
				mag = -mag;
			diff = mag - int'(t.target_speed);
			win = (diff < int'(regs.upper_margin)) && (diff > -int'(regs.lower_margin));
			case (seq.phase)
				PH_RAMP: if (win) seq.phase = PH_PUNCH;
				PH_PUNCH: if (seq.extend_cnt > regs.extend_ticks) begin
					seq.phase = PH_RETRACT;
					seq.extend_cnt = '0;
				end
				PH_RETRACT: if (t.punch_home_switch) begin
					seq.phase = PH_ADVANCE;
					seq.extend_cnt = '0;
				end
				PH_ADVANCE: if (!t.index_switch) seq.phase = PH_ADVANCING;
				PH_ADVANCING: if (t.index_switch) seq.phase = PH_RAMP;
				default: ;
			endcase
			case (seq.phase)
				PH_RAMP: seq.drive = '0;
				PH_PUNCH: begin
					seq.extend = 1'b1;
					if (seq.extend_cnt != COUNT_MAX)
						seq.extend_cnt = seq.extend_cnt + 1'b1;
				end
				PH_RETRACT: begin
					if (seq.prev_phase != PH_RETRACT && seq.punches != COUNT_MAX)
						seq.punches = seq.punches + 1'b1;
					seq.extend = 1'b0;
				end
				PH_ADVANCE, PH_ADVANCING: seq.drive = t.feed_speed;
				default: ;
			endcase
			seq.prev_phase = seq.phase;
		end
		r.phase = seq.phase;
		r.drive = seq.drive;
		r.extend = seq.extend;
		r.count = seq.punches;
		return r;
	endfunction

	function automatic item_t tick(input bit en, input int spd, input int tgt, input int feed,
			input bit home, input bit sw);
		item_t t;
		t.shoot_enable = en;
		t.flywheel_speed = 16'(spd);
		t.target_speed = 14'(tgt);
		t.feed_speed = 16'(feed);
		t.punch_home_switch = home;
		t.index_switch = sw;
		return t;
	endfunction

	function automatic shot_res_t res(input logic [PHASE_W-1:0] ph, input int drv, input bit ext,
			input int cnt);
		shot_res_t r;
		r.phase = ph;
		r.drive = 16'(drv);
		r.extend = ext;
		r.count = 8'(cnt);
		return r;
	endfunction

	function automatic void add_row(input item_t t, input int reps, input bit typed,
			input shot_res_t want);
		dir_row_t row;
		row.tick = t;
		row.reps = reps;
		row.typed = typed;
		row.want = want;
		opening_ticks.push_back(row);
	endfunction

	// clean: no noise, no reset ticks, switches mostly move the sequence on
	function automatic item_t pick_tick(input bit clean);
		item_t t;
		int d;
		int m;
		t.shoot_enable = 1'($urandom);
		t.flywheel_speed = 16'($urandom);
		t.target_speed = 14'($urandom);
		t.feed_speed = 16'($urandom);
		t.punch_home_switch = 1'($urandom);
		t.index_switch = 1'($urandom);
		if (!clean && $urandom_range(0, 99) < 15)
			return t;
		t.shoot_enable = clean ? 1'b1 : ($urandom_range(0, 99) >= 4);
		case (seq.phase)
			PH_RAMP: if (clean || $urandom_range(0, 2) != 0) begin
				t.target_speed = ($urandom_range(0, 3) == 0) ? 14'($urandom)
					: 14'($urandom_range(0, 3000));
				d = int'($urandom_range(0, int'(regs.upper_margin) + int'(regs.lower_margin) + 2))
					- int'(regs.lower_margin) - 1;
				m = int'(t.target_speed) + d;
				if (m < 0)
					m = 0;
				if (m > 32767)
					m = 32767;
				if ($urandom_range(0, 1) != 0)
					m = -m;
				t.flywheel_speed = 16'(m);
			end
			PH_RETRACT: t.punch_home_switch = ($urandom_range(0, 9) < (clean ? 9 : 4));
			PH_ADVANCE: t.index_switch = ($urandom_range(0, 9) >= (clean ? 9 : 6));
			PH_ADVANCING: t.index_switch = ($urandom_range(0, 9) < (clean ? 9 : 4));
			default: ;
		endcase
		return t;
	endfunction

	task automatic send_tick(input item_t t, input bit typed, input shot_res_t want);
		shot_res_t r;
		shoot_enable <= t.shoot_enable;
		flywheel_speed <= t.flywheel_speed;
		target_speed <= t.target_speed;
		feed_speed <= t.feed_speed;
		punch_home_switch <= t.punch_home_switch;
		index_switch <= t.index_switch;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		r = sequence_tick(t);
		due_results.push_back(typed ? want : r);
		sent++;
		if (int'(seq.punches) > peak_punches)
			peak_punches = int'(seq.punches);
		if (int'(seq.extend_cnt) > peak_extend)
			peak_extend = int'(seq.extend_cnt);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				idle_on <= idle_ok && ($urandom_range(0, 3) != 0);
			send_tick(pick_tick(1'b0), 1'b0, '0);
		end
	endtask

	task automatic finish_phase();
		in_valid <= 1'b0;
		while (due_results.size() != 0 || stall_left != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [COUNT_W-1:0] ext, input logic [MARGIN_W-1:0] up,
			input logic [MARGIN_W-1:0] lo);
		cfg_we <= 1'b1;
		cfg_index <= REG_EXTEND_TICKS;
		cfg_data <= {{(CFG_DATA_W-COUNT_W){1'b0}}, ext};
		@(posedge clk);
		cfg_index <= REG_UPPER_MARGIN;
		cfg_data <= up;
		@(posedge clk);
		cfg_index <= REG_LOWER_MARGIN;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		regs.extend_ticks = ext;
		regs.upper_margin = up;
		regs.lower_margin = lo;
	endtask

	function automatic void check_field(input string what, input logic signed [16:0] want,
			input logic signed [16:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0d ns  %s: expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 11);
		out_ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			checked++;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0d ns  unexpected beat: phase %0d drive %0d extend %0d count %0d",
					$time, phase, index_drive, punch_extend, punch_count);
			end else begin
				head = due_results.pop_front();
				check_field("phase", head.phase, phase);
				check_field("index_drive", head.drive, index_drive);
				check_field("punch_extend", head.extend, punch_extend);
				check_field("punch_count", head.count, punch_count);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				due_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		seq = '0;
		seq.phase = PH_RAMP;
		seq.prev_phase = PH_RAMP;
		regs.extend_ticks = RST_EXTEND_TICKS;
		regs.upper_margin = RST_UPPER_MARGIN;
		regs.lower_margin = RST_LOWER_MARGIN;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: extremes, window edges, exact match, one full shot
		add_row(tick(0, 0, 0, 0, 0, 1), 1, 1, res(PH_RAMP, 0, 0, 0));
		add_row(tick(1, -32768, 0, -1, 1, 1), 1, 1, res(PH_RAMP, 0, 0, 0));
		add_row(tick(1, 32767, 16383, 32767, 0, 0), 1, 1, res(PH_RAMP, 0, 0, 0));
		add_row(tick(1, 0, 16383, 0, 1, 0), 1, 1, res(PH_RAMP, 0, 0, 0));
		add_row(tick(1, -1000, 1000, 0, 0, 1), 1, 1, res(PH_PUNCH, 0, 1, 0));
		add_row(tick(0, 0, 0, 0, 0, 0), 1, 1, res(PH_RAMP, 0, 0, 0));
		add_row(tick(1, 1300, 1000, 0, 0, 1), 1, 1, res(PH_RAMP, 0, 0, 0));
		add_row(tick(1, 900, 1000, 0, 0, 1), 1, 1, res(PH_RAMP, 0, 0, 0));
		add_row(tick(1, 1299, 1000, 0, 0, 1), 1, 0, '0);
		add_row(tick(1, 0, 0, 1234, 1, 1), 9, 0, '0);
		add_row(tick(1, 0, 0, 0, 0, 1), 1, 0, '0);
		add_row(tick(1, 0, 0, 0, 0, 1), 1, 0, '0);
		add_row(tick(1, 0, 0, -32768, 1, 1), 1, 0, '0);
		add_row(tick(1, 0, 0, 5, 1, 1), 1, 0, '0);
		add_row(tick(1, 0, 0, 32767, 1, 0), 1, 0, '0);
		add_row(tick(1, 0, 0, -2, 1, 0), 1, 0, '0);
		add_row(tick(0, 0, 0, 0, 0, 0), 1, 0, '0);
		add_row(tick(0, 0, 0, 0, 0, 1), 1, 1, res(PH_RAMP, 0, 0, 0));
		foreach (opening_ticks[i])
			repeat (opening_ticks[i].reps)
				send_tick(opening_ticks[i].tick, opening_ticks[i].typed, opening_ticks[i].want);
		run_random(130);

		// widest window, shortest punch: quick shots
		finish_phase();
		write_regs(8'd0, 12'd4095, 12'd4095);
		run_random(120);

		// exact-match window, punch held until a reset tick
		finish_phase();
		write_regs(8'd255, 12'd1, 12'd1);
		run_random(40);
		while (seq.phase != PH_PUNCH)
			send_tick(pick_tick(1'b1), 1'b0, '0);
		repeat (270) send_tick(pick_tick(1'b1), 1'b0, '0);
		run_random(40);

		finish_phase();
		write_regs(8'd3, 12'd0, 12'd0);
		run_random(60);

		finish_phase();
		write_regs(8'd7, 12'd4095, 12'd0);
		run_random(60);

		// closing stretch, both sides at full rate
		idle_ok = 1'b0;
		idle_on <= 1'b0;
		finish_phase();
		write_regs(8'($urandom_range(0, 20)), 12'($urandom_range(1, 1500)),
			12'($urandom_range(1, 1500)));
		run_random(100);

		finish_phase();
		repeat (6) @(posedge clk);
		$display("%0d ticks sent and %0d result beats checked over six register settings",
			sent, checked);
		$display("peak punch count %0d, peak extend counter %0d", peak_punches, peak_extend);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sfs_pkg.sv
rtl/sfs_in_stage.sv
rtl/sfs_step.sv
rtl/shot_feed_sequencer_core.sv
rtl/sfs_checker.sv
bench/shot_feed_sequencer_core_tb.sv
